[sv/mcbrf_pkg.sv]
// Package for the multi-channel byte ring FIFO.
// Holds the field widths, codes, defaults and the result struct.
// No dependencies.
package mcbrf_pkg;

    localparam int MCBRF_CHANNELS = 4;
    localparam int MCBRF_DEPTH    = 256;

    // Four size registers always exist, whatever CHANNELS is set to.
    localparam int SIZE_REGS  = 4;
    localparam int CH_W       = 2;
    localparam int BYTE_W     = 8;
    localparam int SIZE_W     = 9;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DISABLED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd4;

    typedef struct packed {
        logic                data_valid;
        logic [BYTE_W-1:0]   bytes_available;
        logic [STATUS_W-1:0] status;
        logic                last_out;
    } t_result;

endpackage

[sv/mcbrf_intf.sv]
// Handshake interfaces: command stream in, result stream out, config writes.
// Depends on mcbrf_pkg.
interface mcbrf_in_if import mcbrf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [CH_W-1:0]   channel;
    logic [BYTE_W-1:0] data_in;
    logic              last_of_request;

    modport source (output valid, cmd, channel, data_in, last_of_request, input ready);
    modport sink   (input valid, cmd, channel, data_in, last_of_request, output ready);
endinterface

interface mcbrf_out_if import mcbrf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   read_data;
    logic                data_valid;
    logic [BYTE_W-1:0]   bytes_available;
    logic [STATUS_W-1:0] status;
    logic                last_out;

    modport source (output valid, read_data, data_valid, bytes_available, status, last_out,
                    input ready);
    modport sink   (input valid, read_data, data_valid, bytes_available, status, last_out,
                    output ready);
endinterface

interface mcbrf_cfg_if import mcbrf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/mcbrf_ram.sv]
// Generic single-port RAM with registered read, no reset on contents.
// No dependencies.
module mcbrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/mcbrf_ctrl.sv]
// Pointer and configuration control: size/enable registers, per-channel ring
// pointers, store access generation and result fields. Depends on mcbrf_pkg.
module mcbrf_ctrl import mcbrf_pkg::*; #(
    parameter int CHANNELS = MCBRF_CHANNELS,
    parameter int DEPTH    = MCBRF_DEPTH,
    localparam int ACT     = (CHANNELS < SIZE_REGS) ? CHANNELS : SIZE_REGS,
    localparam int AIDX_W  = (ACT > 1) ? $clog2(ACT) : 1,
    localparam int PW      = $clog2(DEPTH),
    localparam int ADDR_W  = AIDX_W + PW
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mcbrf_in_if.sink          i_in,
    mcbrf_cfg_if.sink         i_cfg,
    input  logic              i_out_free,
    output logic              o_ram_we,
    output logic              o_ram_re,
    output logic [ADDR_W-1:0] o_ram_addr,
    output logic [BYTE_W-1:0] o_ram_wdata,
    output logic              o_res_load,
    output t_result           o_res
);

    localparam int PTR_N = 2 ** AIDX_W;
    localparam logic [SIZE_W-1:0] DEPTH_S = SIZE_W'(DEPTH);

    logic [SIZE_W-1:0] r_size [SIZE_REGS];
    logic [SIZE_REGS-1:0] r_enable;
    logic [PW-1:0] r_wp [PTR_N];
    logic [PW-1:0] r_rp [PTR_N];

    logic [AIDX_W-1:0] idx;
    logic              ch_en;
    logic [SIZE_W-1:0] size_raw;
    logic [SIZE_W-1:0] size_eff;
    logic [PW-1:0]     wp;
    logic [PW-1:0]     rp;
    logic [PW-1:0]     n_wp;
    logic [PW-1:0]     n_rp;
    logic [SIZE_W-1:0] avail_pre;
    logic [SIZE_W-1:0] avail_post;
    logic              take;
    logic              is_write;
    logic              rd_ok;
    logic              cfg_take;

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                              input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] nxt;
        nxt = SIZE_W'(p) + SIZE_W'(1);
        return (nxt >= s) ? '0 : nxt[PW-1:0];
    endfunction

    function automatic logic [SIZE_W-1:0] fill(input logic [PW-1:0] w,
                                               input logic [PW-1:0] r,
                                               input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] ws;
        logic [SIZE_W-1:0] rs;
        ws = SIZE_W'(w);
        rs = SIZE_W'(r);
        return (ws >= rs) ? (ws - rs) : (ws + s - rs);
    endfunction

    // A config write owns the pointer registers for its cycle.
    assign i_in.ready  = i_out_free && !i_cfg.valid;
    assign i_cfg.ready = 1'b1;
    assign take        = i_in.valid && i_in.ready;
    assign cfg_take    = i_cfg.valid && i_cfg.ready;

    always_comb begin
        idx      = i_in.channel[AIDX_W-1:0];
        ch_en    = (32'(i_in.channel) < CHANNELS) && r_enable[i_in.channel];
        size_raw = r_size[i_in.channel];
        // Out-of-range sizes fall back to the full ring.
        size_eff = (size_raw == '0 || size_raw > DEPTH_S) ? DEPTH_S : size_raw;
        wp       = r_wp[idx];
        rp       = r_rp[idx];
        is_write = (i_in.cmd == CMD_WRITE);
        avail_pre = fill(wp, rp, size_eff);
        rd_ok    = !is_write && (avail_pre != '0);
        n_wp     = is_write ? advance(wp, size_eff) : wp;
        n_rp     = rd_ok ? advance(rp, size_eff) : rp;
        avail_post = fill(n_wp, n_rp, size_eff);
    end

    assign o_ram_we    = take && ch_en && is_write;
    assign o_ram_re    = take && ch_en && rd_ok;
    assign o_ram_addr  = {idx, (is_write ? wp : rp)};
    assign o_ram_wdata = i_in.data_in;
    assign o_res_load  = take;

    always_comb begin
        o_res.last_out = i_in.last_of_request;
        if (!ch_en) begin
            o_res.data_valid      = 1'b0;
            o_res.bytes_available = '0;
            o_res.status          = STATUS_DISABLED;
        end else begin
            o_res.data_valid      = rd_ok;
            o_res.bytes_available = avail_post[BYTE_W-1:0];
            o_res.status          = (is_write || rd_ok) ? STATUS_OK : STATUS_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SIZE_REGS; i++) begin
                r_size[i] <= SIZE_RESET;
            end
            r_enable <= '0;
            for (int i = 0; i < PTR_N; i++) begin
                r_wp[i] <= '0;
                r_rp[i] <= '0;
            end
        end else if (cfg_take) begin
            if (i_cfg.index < REG_ENABLE) begin
                r_size[i_cfg.index[CH_W-1:0]] <= i_cfg.data;
                // Resizing restarts the ring so pointers stay below the size.
                if (32'(i_cfg.index) < ACT) begin
                    r_wp[i_cfg.index[AIDX_W-1:0]] <= '0;
                    r_rp[i_cfg.index[AIDX_W-1:0]] <= '0;
                end
            end else if (i_cfg.index == REG_ENABLE) begin
                r_enable <= i_cfg.data[SIZE_REGS-1:0];
            end
        end else if (take && ch_en) begin
            r_wp[idx] <= n_wp;
            r_rp[idx] <= n_rp;
        end
    end

endmodule

[sv/multi_channel_byte_ring_fifo.sv]
// Top level of the multi-channel byte ring FIFO: control, shared byte store
// and result register. Depends on mcbrf_pkg, mcbrf_intf, mcbrf_ram, mcbrf_ctrl.
//
//   port    dir   transaction
//   i_in    in    cmd, channel, data_in, last_of_request
//   o_out   out   read_data, data_valid, bytes_available, status, last_out
//   i_cfg   in    index (0..3 size, 4 enable), data
//
// One command per cycle unless the result stalls or a config write is offered;
// its result shows in the cycle after acceptance, via the store's registered read.
// Reset clears sizes to 256, enables and all ring pointers; the store is
// not cleared. A stalled result holds; a new command is taken in the same
// cycle the pending result leaves. Config writes are always ready; while
// one is offered, commands are held off.
module multi_channel_byte_ring_fifo import mcbrf_pkg::*; #(
    parameter int CHANNELS = MCBRF_CHANNELS,
    parameter int DEPTH    = MCBRF_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcbrf_in_if.sink   i_in,
    mcbrf_out_if.source o_out,
    mcbrf_cfg_if.sink  i_cfg
);

    localparam int ACT    = (CHANNELS < SIZE_REGS) ? CHANNELS : SIZE_REGS;
    localparam int AIDX_W = (ACT > 1) ? $clog2(ACT) : 1;
    localparam int PW     = $clog2(DEPTH);
    localparam int ADDR_W = AIDX_W + PW;
    localparam int MEM_N  = 2 ** ADDR_W;

    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [BYTE_W-1:0] ram_rdata;
    logic              res_load;
    t_result           res;
    logic              out_free;

    logic    r_out_valid;
    t_result r_res;

    assign out_free = !r_out_valid || o_out.ready;

    mcbrf_ctrl #(
        .CHANNELS (CHANNELS),
        .DEPTH    (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (i_cfg),
        .i_out_free  (out_free),
        .o_ram_we    (ram_we),
        .o_ram_re    (ram_re),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .o_res_load  (res_load),
        .o_res       (res)
    );

    // Read data stays put until the next successful read, which cannot be
    // issued before the pending result is taken.
    mcbrf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MEM_N)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_res <= res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.read_data       = r_res.data_valid ? ram_rdata : '0;
    assign o_out.data_valid      = r_res.data_valid;
    assign o_out.bytes_available = r_res.bytes_available;
    assign o_out.status          = r_res.status;
    assign o_out.last_out        = r_res.last_out;

endmodule
